### src/isc_pkg.sv
// ----------------------------------------------------------------------------
// isc_pkg: shared types and constants for the integral step size controller
// Fixed-point formats, register indexes, stage payloads and the exp2 table.
// ----------------------------------------------------------------------------
package isc_pkg;

  localparam int STEP_W   = 32;  // Q16.16 step size
  localparam int ERR_W    = 32;  // Q8.24 error estimate
  localparam int FIX_W    = 16;  // Q4.12 gain and bias
  localparam int ORD_W    = 4;
  localparam int MANT_W   = 31;  // Q1.30 mantissa
  localparam int FRAC_W   = 16;  // fraction bits of a log
  localparam int TOP_W    = 5;   // index of the top set bit of an error word
  localparam int BTOP_W   = 4;   // index of the top set bit of a bias word
  localparam int LOG_W    = 23;  // signed Q.16 biased error log
  localparam int MAG_W    = 40;  // |gain * log|, dividend of the order divide
  localparam int DIV_STG  = 5;   // divide stages
  localparam int DIV_BITS = MAG_W / DIV_STG;
  localparam int XP_W     = 28;  // signed Q.16 exponent
  localparam int EXPI_W   = XP_W - FRAC_W;
  localparam int PROD_W   = STEP_W + MANT_W;
  localparam int SHIFT_W  = EXPI_W + 1;
  localparam int ERR_FRAC = 24;
  localparam int BIAS_FRAC = 12;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam logic [FIX_W-1:0] BIAS_DEFAULT  = FIX_W'(6144);
  localparam logic [FIX_W-1:0] GAIN_RESET    = FIX_W'(4096);
  localparam logic [ORD_W-1:0] ORDER_RESET   = ORD_W'(1);
  localparam logic [LOG_W-1:0] LOG_OFFSET    = LOG_W'((ERR_FRAC + BIAS_FRAC) * 65536);
  localparam logic [LOG_W-1:0] LOG_FLOOR     = LOG_W'(-(ERR_FRAC * 65536));
  localparam logic [MANT_W-1:0] MANT_ONE     = MANT_W'(64'd1 << 30);
  localparam logic [SHIFT_W-1:0] MANT_POINT  = SHIFT_W'(30);

  typedef enum logic [1:0] {
    REG_GAIN  = 2'd0,
    REG_BIAS  = 2'd1,
    REG_ORDER = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [FIX_W-1:0] gain;
    logic [FIX_W-1:0] bias;
    logic [ORD_W-1:0] order;
  } cfg_t;

  typedef struct packed {
    logic [STEP_W-1:0]       step;
    logic signed [LOG_W-1:0] lg;
  } log_res_t;

  typedef struct packed {
    logic [STEP_W-1:0]        step;
    logic signed [EXPI_W-1:0] ipart;
    logic [FRAC_W-1:0]        fpart;
  } pow_arg_t;

  typedef struct packed {
    logic [STEP_W-1:0]        step;
    logic signed [EXPI_W-1:0] ipart;
    logic [MANT_W-1:0]        mant;
  } scale_t;

  function automatic logic [TOP_W-1:0] top_bit(input logic [ERR_W-1:0] x);
    logic [TOP_W-1:0] m;
    m = '0;
    for (int i = 1; i < ERR_W; i++) begin
      if (x[i]) m = TOP_W'(i);
    end
    return m;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] rem;
    r = '0;
    b = 64'd1 << 62;
    rem = v;
    for (int i = 0; i < 32; i++) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(2^-k) in Q1.30 by repeated floor square roots
  function automatic logic [MANT_W-1:0] exp_coef(input int k);
    logic [63:0] c;
    c = isqrt64(64'd1 << 61);
    for (int j = 1; j < k; j++) begin
      c = isqrt64(c << 30);
    end
    return c[MANT_W-1:0];
  endfunction

endpackage

### src/isc_log.sv
// ----------------------------------------------------------------------------
// isc_log: biased error log pipeline
// Normalizes error and bias, squares out 16 fraction bits each, and forms
// the signed Q.16 log of the biased error with its one-LSB floor.
// ----------------------------------------------------------------------------
module isc_log (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic [isc_pkg::STEP_W-1:0] in_step,
  input  logic [isc_pkg::ERR_W-1:0]  in_err,
  input  logic [isc_pkg::FIX_W-1:0]  bias,
  output logic                     out_vld,
  output isc_pkg::log_res_t        out_res
);
  import isc_pkg::*;

  localparam int SQ = FRAC_W;

  logic              v0, v1;
  logic [STEP_W-1:0] stp0, stp1;
  logic [ERR_W-1:0]  err0, err1;
  logic              flr1;
  logic [TOP_W-1:0]  me1;
  logic [BTOP_W-1:0] mb1;

  logic [SQ:0]       lv;
  logic [STEP_W-1:0] lstp [0:SQ];
  logic [MANT_W-1:0] lye  [0:SQ];
  logic [MANT_W-1:0] lyb  [0:SQ];
  logic [FRAC_W-1:0] lfe  [0:SQ];
  logic [FRAC_W-1:0] lfb  [0:SQ];
  logic [TOP_W-1:0]  lme  [0:SQ];
  logic [BTOP_W-1:0] lmb  [0:SQ];
  logic              lflr [0:SQ];

  logic [27:0]               small_prod;
  logic [TOP_W-1:0]          mb_full;
  logic [ERR_W+MANT_W-2:0]   nrm_e;
  logic [FIX_W+MANT_W-2:0]   nrm_b;
  logic [LOG_W-1:0]          lsum;

  always_comb begin
    small_prod = 28'(err0[11:0]) * 28'(bias);
    mb_full    = top_bit(ERR_W'(bias));
    nrm_e      = {err1, 30'b0} >> me1;
    nrm_b      = {bias, 30'b0} >> mb1;
    lsum       = LOG_W'({lme[SQ], lfe[SQ]}) + LOG_W'({lmb[SQ], lfb[SQ]}) - LOG_OFFSET;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0      <= 1'b0;
      v1      <= 1'b0;
      lv      <= '0;
      out_vld <= 1'b0;
    end else if (en) begin
      v0      <= in_vld;
      v1      <= v0;
      lv      <= {lv[SQ-1:0], v1};
      out_vld <= lv[SQ];
    end
    if (en) begin
      stp0     <= in_step;
      err0     <= in_err;
      stp1     <= stp0;
      err1     <= err0;
      flr1     <= (err0[ERR_W-1:12] == '0) && (small_prod < 28'd4096);
      me1      <= top_bit(err0);
      mb1      <= mb_full[BTOP_W-1:0];
      lstp[0]  <= stp1;
      lye[0]   <= nrm_e[MANT_W-1:0];
      lyb[0]   <= nrm_b[MANT_W-1:0];
      lfe[0]   <= '0;
      lfb[0]   <= '0;
      lme[0]   <= me1;
      lmb[0]   <= mb1;
      lflr[0]  <= flr1;
      out_res.step <= lstp[SQ];
      out_res.lg   <= lflr[SQ] ? LOG_FLOOR : lsum;
    end
  end

  // one fraction bit per stage: square, renormalize into [1,2)
  for (genvar k = 1; k <= SQ; k++) begin : g_sq
    logic [2*MANT_W-1:0] pe, pb;
    always_comb begin
      pe = lye[k-1] * lye[k-1];
      pb = lyb[k-1] * lyb[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        lye[k]  <= pe[2*MANT_W-1] ? pe[2*MANT_W-1:MANT_W] : pe[2*MANT_W-2:MANT_W-1];
        lyb[k]  <= pb[2*MANT_W-1] ? pb[2*MANT_W-1:MANT_W] : pb[2*MANT_W-2:MANT_W-1];
        lfe[k]  <= {lfe[k-1][FRAC_W-2:0], pe[2*MANT_W-1]};
        lfb[k]  <= {lfb[k-1][FRAC_W-2:0], pb[2*MANT_W-1]};
        lstp[k] <= lstp[k-1];
        lme[k]  <= lme[k-1];
        lmb[k]  <= lmb[k-1];
        lflr[k] <= lflr[k-1];
      end
    end
  end

endmodule

### src/isc_div.sv
// ----------------------------------------------------------------------------
// isc_div: exponent pipeline
// Multiplies the log by the gain, divides the magnitude by the order eight
// quotient bits per stage, and splits the exponent into integer and fraction.
// ----------------------------------------------------------------------------
module isc_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_vld,
  input  isc_pkg::log_res_t        in_res,
  input  logic [isc_pkg::FIX_W-1:0] gain,
  input  logic [isc_pkg::ORD_W-1:0] order,
  output logic                     out_vld,
  output isc_pkg::pow_arg_t        out_arg
);
  import isc_pkg::*;

  logic [DIV_STG:0]  dv;
  logic [STEP_W-1:0] dstp [0:DIV_STG];
  logic              dneg [0:DIV_STG];
  logic [MAG_W-1:0]  dw   [0:DIV_STG];
  logic [ORD_W-1:0]  drem [0:DIV_STG];

  logic signed [MAG_W-1:0] t;
  logic [MAG_W-1:0]        qs;
  logic [XP_W-1:0]         xmag;
  logic [XP_W-1:0]         xval;

  always_comb begin
    t    = $signed({1'b0, gain}) * in_res.lg;
    qs   = dw[DIV_STG] >> BIAS_FRAC;
    xmag = qs[XP_W-1:0];
    // exponent is minus gain*log/order: flip the sign of the magnitude
    xval = dneg[DIV_STG] ? xmag : XP_W'(-xmag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv      <= '0;
      out_vld <= 1'b0;
    end else if (en) begin
      dv      <= {dv[DIV_STG-1:0], in_vld};
      out_vld <= dv[DIV_STG];
    end
    if (en) begin
      dstp[0] <= in_res.step;
      dneg[0] <= t[MAG_W-1];
      dw[0]   <= t[MAG_W-1] ? MAG_W'(-t) : MAG_W'(t);
      drem[0] <= '0;
      out_arg.step  <= dstp[DIV_STG];
      out_arg.ipart <= xval[XP_W-1:FRAC_W];
      out_arg.fpart <= xval[FRAC_W-1:0];
    end
  end

  for (genvar d = 1; d <= DIV_STG; d++) begin : g_div
    logic [MAG_W-1:0] w_t;
    logic [ORD_W-1:0] r_t;
    logic [ORD_W:0]   tr;
    logic             q;
    always_comb begin
      w_t = dw[d-1];
      r_t = drem[d-1];
      tr  = '0;
      q   = 1'b0;
      for (int j = 0; j < DIV_BITS; j++) begin
        tr = {r_t, w_t[MAG_W-1]};
        if (tr >= {1'b0, order}) begin
          r_t = ORD_W'(tr - {1'b0, order});
          q   = 1'b1;
        end else begin
          r_t = tr[ORD_W-1:0];
          q   = 1'b0;
        end
        w_t = {w_t[MAG_W-2:0], q};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dstp[d] <= dstp[d-1];
        dneg[d] <= dneg[d-1];
        dw[d]   <= w_t;
        drem[d] <= r_t;
      end
    end
  end

endmodule

### src/isc_exp.sv
// ----------------------------------------------------------------------------
// isc_exp: fractional power of two pipeline
// One table constant per fraction bit, one conditional multiply per stage.
// ----------------------------------------------------------------------------
module isc_exp (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  isc_pkg::pow_arg_t in_arg,
  output logic              out_vld,
  output isc_pkg::scale_t   out_scl
);
  import isc_pkg::*;

  localparam int NS = FRAC_W;

  logic [NS:0]              ev;
  logic [STEP_W-1:0]        estp [0:NS];
  logic signed [EXPI_W-1:0] eip  [0:NS];
  logic [FRAC_W-1:0]        efr  [0:NS];
  logic [MANT_W-1:0]        emt  [0:NS];

  always_comb begin
    ev[0]   = in_vld;
    estp[0] = in_arg.step;
    eip[0]  = in_arg.ipart;
    efr[0]  = in_arg.fpart;
    emt[0]  = MANT_ONE;
    out_vld = ev[NS];
    out_scl.step  = estp[NS];
    out_scl.ipart = eip[NS];
    out_scl.mant  = emt[NS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev[NS:1] <= '0;
    end else if (en) begin
      ev[NS:1] <= ev[NS-1:0];
    end
  end

  for (genvar k = 1; k <= NS; k++) begin : g_exp
    localparam logic [MANT_W-1:0] COEF = exp_coef(k);
    logic [2*MANT_W-1:0] p;
    always_comb p = emt[k-1] * COEF;
    always_ff @(posedge clk) begin
      if (en) begin
        emt[k]  <= efr[k-1][FRAC_W-k] ? p[2*MANT_W-2:MANT_W-1] : emt[k-1];
        estp[k] <= estp[k-1];
        eip[k]  <= eip[k-1];
        efr[k]  <= efr[k-1];
      end
    end
  end

endmodule

### src/isc_out.sv
// ----------------------------------------------------------------------------
// isc_out: scale and saturate
// Multiplies the step by the mantissa, applies the integer exponent as a
// shift and clips to the largest step, holding the result word for output.
// ----------------------------------------------------------------------------
module isc_out (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_vld,
  input  isc_pkg::scale_t           in_scl,
  output logic                      out_vld,
  output logic [isc_pkg::STEP_W-1:0] out_step,
  output logic                      out_sat
);
  import isc_pkg::*;

  logic               pv;
  logic [PROD_W-1:0]  prod;
  logic [SHIFT_W-1:0] sh;

  logic [SHIFT_W-1:0] rs;
  logic [PROD_W-1:0]  rt;
  logic [STEP_W-1:0]  val;
  logic               sat;

  always_comb begin
    rs  = SHIFT_W'(-sh);
    rt  = prod >> rs[5:0];
    val = '0;
    sat = 1'b0;
    if (prod == '0) begin
      val = '0;
    end else if (!sh[SHIFT_W-1]) begin
      if (sh >= SHIFT_W'(STEP_W)) begin
        sat = 1'b1;
      end else begin
        sat = (prod >> (6'd32 - {1'b0, sh[4:0]})) != '0;
        val = STEP_W'(prod << sh[4:0]);
      end
    end else if (rs < SHIFT_W'(PROD_W)) begin
      sat = rt[PROD_W-1:STEP_W] != '0;
      val = rt[STEP_W-1:0];
    end
    if (sat) val = '1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv      <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      pv      <= in_vld;
      out_vld <= pv;
    end
    if (en) begin
      prod     <= in_scl.step * in_scl.mant;
      sh       <= SHIFT_W'(in_scl.ipart) - MANT_POINT;
      out_step <= val;
      out_sat  <= sat;
    end
  end

endmodule

### src/integral_step_size_controller.sv
// ----------------------------------------------------------------------------
// integral_step_size_controller: I controller for adaptive time steps
// Proposes step * (bias * error)^(-gain/order) in fixed point.
// ----------------------------------------------------------------------------
// Takes one word per cycle while the output word does not wait and returns
// one word per input; the log2 and exp2 units hold the two 16-stage squaring
// and multiply chains, each log2 stage holding two 31x31 squarers and each
// exp2 stage one 31x31 multiplier. Input tdata
// holds step_size (Q16.16) low and error_estimate (Q8.24) high; output tdata
// is new_step (Q16.16) and tuser flags a result clipped to all ones. The
// error is scaled by the bias and floored at one LSB before the log. Write
// gain, error_bias and controller_order over APB at 0x0, 0x4 and 0x8 only
// while no word is in flight; a bias of zero selects 1.5, an order of zero
// acts as one. The pipeline stalls as a whole when the output word waits.
module integral_step_size_controller (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [63:0]                s_tdata,   // step_size[31:0], error_estimate[63:32]
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [31:0]                m_tdata,   // new_step[31:0]
  output logic                       m_tuser,   // saturated[0]
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [isc_pkg::ADDR_W-1:0] paddr,
  input  logic [isc_pkg::DATA_W-1:0] pwdata,
  output logic [isc_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import isc_pkg::*;

  cfg_t       cfg;
  logic       en;
  logic       cfg_wr;
  reg_idx_t   widx;
  logic [FIX_W-1:0] bias_eff;
  logic [ORD_W-1:0] ord_eff;

  logic       lg_vld, dv_vld, ex_vld;
  log_res_t   lg_res;
  pow_arg_t   dv_arg;
  scale_t     ex_scl;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign widx     = reg_idx_t'(paddr[3:2]);
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign bias_eff = (cfg.bias == '0) ? BIAS_DEFAULT : cfg.bias;
  assign ord_eff  = (cfg.order == '0) ? ORD_W'(1) : cfg.order;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain  <= GAIN_RESET;
      cfg.bias  <= BIAS_DEFAULT;
      cfg.order <= ORDER_RESET;
    end else if (cfg_wr) begin
      unique case (widx)
        REG_GAIN:  cfg.gain  <= pwdata[FIX_W-1:0];
        REG_BIAS:  cfg.bias  <= pwdata[FIX_W-1:0];
        REG_ORDER: cfg.order <= pwdata[ORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_GAIN:  prdata = DATA_W'(cfg.gain);
      REG_BIAS:  prdata = DATA_W'(cfg.bias);
      REG_ORDER: prdata = DATA_W'(cfg.order);
      default:   prdata = '0;
    endcase
  end

  isc_log u_log (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (s_tvalid && s_tready),
    .in_step (s_tdata[31:0]),
    .in_err  (s_tdata[63:32]),
    .bias    (bias_eff),
    .out_vld (lg_vld),
    .out_res (lg_res)
  );

  isc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (lg_vld),
    .in_res  (lg_res),
    .gain    (cfg.gain),
    .order   (ord_eff),
    .out_vld (dv_vld),
    .out_arg (dv_arg)
  );

  isc_exp u_exp (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (dv_vld),
    .in_arg  (dv_arg),
    .out_vld (ex_vld),
    .out_scl (ex_scl)
  );

  isc_out u_out (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (ex_vld),
    .in_scl   (ex_scl),
    .out_vld  (m_tvalid),
    .out_step (m_tdata),
    .out_sat  (m_tuser)
  );

  a_sat_ones: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '1)
    else $error("saturated word without all-ones step");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while output word waits");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output word valid right after reset");

endmodule
